@@ src/pattern_find_replace_defines.svh @@
// assertion macros shared by the find-and-replace modules
`ifndef PATTERN_FIND_REPLACE_DEFINES_SVH
`define PATTERN_FIND_REPLACE_DEFINES_SVH

// invariant checked at every clock edge out of reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked out of reset
`define PFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/pfr_pkg.sv @@
// types and constants shared by the find-and-replace modules
`default_nettype none

package pfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int BYTE_W      = 8;
  localparam int WIN_DEPTH   = 8;
  localparam int WORD_W      = BYTE_W * WIN_DEPTH;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 64;

  // one input request
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  // one result request
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              out_last;
  } out_item_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [WORD_W-1:0] pat;
    logic [CNT_W-1:0]  plen;
    logic [WORD_W-1:0] rep;
    logic [CNT_W-1:0]  rlen;
    logic              win_clr;
  } cfg_t;

  // one job from the front: up to eight result bytes plus end mark
  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } job_t;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PATTERN_LEN   = 2'd1,
    REG_REPLACE_BYTES = 2'd2,
    REG_REPLACE_LEN   = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

@@ src/pfr_cfg.sv @@
// configuration register file with apb-style access
`default_nettype none

module pfr_cfg import pfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [WORD_W-1:0] pat_r;
  logic [CNT_W-1:0]  plen_r;
  logic [WORD_W-1:0] rep_r;
  logic [CNT_W-1:0]  rlen_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= CNT_W'(1);
      rep_r  <= '0;
      rlen_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PATTERN_BYTES: pat_r  <= pwdata[WORD_W-1:0];
        REG_PATTERN_LEN:   plen_r <= pwdata[CNT_W-1:0];
        REG_REPLACE_BYTES: rep_r  <= pwdata[WORD_W-1:0];
        REG_REPLACE_LEN:   rlen_r <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PATTERN_BYTES: prdata = CFG_DW'(pat_r);
      REG_PATTERN_LEN:   prdata = CFG_DW'(plen_r);
      REG_REPLACE_BYTES: prdata = CFG_DW'(rep_r);
      REG_REPLACE_LEN:   prdata = CFG_DW'(rlen_r);
    endcase
  end

  // effective lengths, saturated into their legal ranges
  always_comb begin
    cfg.pat = pat_r;
    cfg.rep = rep_r;
    if (plen_r == '0) begin
      cfg.plen = CNT_W'(1);
    end else if (plen_r > CNT_W'(MAX_PATTERN)) begin
      cfg.plen = CNT_W'(MAX_PATTERN);
    end else begin
      cfg.plen = plen_r;
    end
    if (rlen_r > CNT_W'(MAX_REPLACE)) begin
      cfg.rlen = CNT_W'(MAX_REPLACE);
    end else begin
      cfg.rlen = rlen_r;
    end
    // new pattern length drops the window
    cfg.win_clr = wr_en && (idx == REG_PATTERN_LEN);
  end

endmodule

`default_nettype wire

@@ src/pfr_front.sv @@
// front end: window of unconfirmed bytes, parallel compare, job build
`default_nettype none

`include "pattern_find_replace_defines.svh"

module pfr_front import pfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  cfg_t          cfg,
  input  wire logic     push,
  input  in_item_t      in_data,
  output logic          full,
  input  wire logic     q_full,
  output logic          job_push,
  output job_t          job
);

  logic [WORD_W-1:0]  win_r;
  logic [WORD_W-1:0]  win_nxt;
  logic [CNT_W-1:0]   win_cnt_r;
  logic [CNT_W-1:0]   win_cnt_nxt;
  logic [WORD_W-1:0]  wn;
  logic [CNT_W-1:0]   cn;
  logic [WIN_DEPTH:0] ok;
  logic               fullm;
  logic [CNT_W-1:0]   kpick;
  logic               accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // append, compare every suffix against the pattern, pick the result
  always_comb begin
    logic [CNT_W-1:0] len_v;
    wn = win_r;
    wn[{win_cnt_r[IDX_W-1:0], 3'b000} +: BYTE_W] = in_data.in_byte;
    cn = win_cnt_r + CNT_W'(1);

    // suffix starting at k still a proper prefix of the pattern
    for (int k = 0; k <= WIN_DEPTH; k++) begin
      len_v = cn - CNT_W'(k);
      ok[k] = (CNT_W'(k) <= cn) && (len_v < cfg.plen);
      for (int j = 0; j < WIN_DEPTH; j++) begin
        if (k + j < WIN_DEPTH) begin
          if ((CNT_W'(j) < len_v) &&
              (wn[BYTE_W*(k+j) +: BYTE_W] != cfg.pat[BYTE_W*j +: BYTE_W])) begin
            ok[k] = 1'b0;
          end
        end
      end
    end

    // whole window equals the whole pattern
    fullm = (cn == cfg.plen);
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if ((CNT_W'(j) < cfg.plen) &&
          (wn[BYTE_W*j +: BYTE_W] != cfg.pat[BYTE_W*j +: BYTE_W])) begin
        fullm = 1'b0;
      end
    end

    // oldest surviving start position
    kpick = CNT_W'(WIN_DEPTH);
    for (int k = WIN_DEPTH; k >= 0; k--) begin
      if (ok[k]) begin
        kpick = CNT_W'(k);
      end
    end

    job.last = in_data.in_last;
    priority if (fullm) begin
      job.bytes   = cfg.rep;
      job.cnt     = cfg.rlen;
      win_nxt     = wn;
      win_cnt_nxt = '0;
    end else if (in_data.in_last) begin
      job.bytes   = wn;
      job.cnt     = cn;
      win_nxt     = wn;
      win_cnt_nxt = '0;
    end else begin
      job.bytes   = wn;
      job.cnt     = kpick;
      win_nxt     = wn >> {kpick, 3'b000};
      win_cnt_nxt = cn - kpick;
    end

    job_push = accept && ((job.cnt != '0) || in_data.in_last);
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  // window fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
    end else if (cfg.win_clr) begin
      win_cnt_r <= '0;
    end else if (accept) begin
      win_cnt_r <= win_cnt_nxt;
    end
  end

  `PFR_ASSERT(a_win_proper_prefix, win_cnt_r < cfg.plen, "window holds a full pattern length")
  `PFR_ASSERT_IMP(a_job_bounded, job_push, job.cnt <= CNT_W'(WIN_DEPTH), "job longer than eight")

endmodule

`default_nettype wire

@@ src/pfr_queue.sv @@
// short job queue between front and back
`default_nettype none

`include "pattern_find_replace_defines.svh"

module pfr_queue import pfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      job_in,
  output logic      full,
  input  wire logic pop,
  output job_t      job_out,
  output logic      empty
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `PFR_ASSERT(a_cnt_range, cnt_r <= QCNT_W'(QDEPTH), "job queue fill out of range")
  `PFR_ASSERT_IMP(a_no_push_full, push, !full, "job pushed into a full queue")

endmodule

`default_nettype wire

@@ src/pfr_back.sv @@
// back end: walks each job one byte a cycle into the output register while it is free or popped
`default_nettype none

`include "pattern_find_replace_defines.svh"

module pfr_back import pfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  job_t      job,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_data
);

  logic [IDX_W-1:0] idx_r;
  logic             out_vld_r;
  out_item_t        out_r;
  out_item_t        out_nxt;
  logic             fin;
  logic             load;

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  // next result from the head job
  always_comb begin
    fin   = (job.cnt == '0) || (CNT_W'(idx_r) == job.cnt - CNT_W'(1));
    load  = !q_empty && (!out_vld_r || pop);
    q_pop = load && fin;
    out_nxt.has_byte = (job.cnt != '0);
    out_nxt.out_byte = (job.cnt == '0) ? '0 : job.bytes[{idx_r, 3'b000} +: BYTE_W];
    out_nxt.out_last = job.last && fin;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  // output valid and byte index within the job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      if (load) begin
        idx_r <= fin ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  `PFR_ASSERT_IMP(a_empty_job_ends, !q_empty && (job.cnt == '0), job.last, "empty job without end mark")
  `PFR_ASSERT_IMP(a_idx_in_job, !q_empty && (job.cnt != '0), CNT_W'(idx_r) < job.cnt, "byte index past job")

endmodule

`default_nettype wire

@@ src/pattern_find_replace.sv @@
// An accepted item's job is queued, then its first result is loaded into the output register.
// Throughput: one item a cycle while the four-entry job queue has room; results
// leave one a cycle while popped; the back end holds each job until its last result.
// Matching is one parallel compare of every window suffix in the front stage.
// Reset (rst_n low, synchronous): window empty, queue and output empty,
// pattern_len 1 and every other register zero.
`default_nettype none

module pattern_find_replace import pfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  in_item_t               in_data,
  output logic                   empty,
  input  wire logic              pop,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  job_t job_in;
  job_t job_head;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // registers
  pfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // match and classify
  pfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_in)
  );

  // decoupling queue
  pfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .job_in  (job_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (job_head),
    .empty   (q_empty)
  );

  // result serializer
  pfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ bench/pfr_checker.sv @@
// checker for the find-and-replace block: predicts results from accepted requests and compares
module pfr_checker import pfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  in_item_t          in_data,
  input  logic              empty,
  input  logic              pop,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                pending
);

  localparam int PRINT_CAP = 40;

  // shadow copy of the configuration registers
  logic [WORD_W-1:0] pat_word;
  logic [CNT_W-1:0]  pat_len_reg;
  logic [WORD_W-1:0] rep_word;
  logic [CNT_W-1:0]  rep_len_reg;

  // bytes that may still start a match, oldest first
  logic [BYTE_W-1:0] window [WIN_DEPTH];
  int unsigned       win_fill;

  // result requests still owed by the block, oldest first
  out_item_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want_v, got_v);
  endtask

  // first n window bytes agree with the pattern
  function automatic bit window_prefix_ok(input int unsigned n);
    for (int i = 0; i < n && i < WIN_DEPTH; i++) begin
      if (window[i] != pat_word[i*BYTE_W +: BYTE_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] window_take_oldest();
    logic [BYTE_W-1:0] b;
    b = window[0];
    for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i+1];
    window[WIN_DEPTH-1] = '0;
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  function automatic out_item_t make_result(input logic [BYTE_W-1:0] b, input logic has);
    out_item_t r;
    r.out_byte = b;
    r.has_byte = has;
    r.out_last = 1'b0;
    return r;
  endfunction

  // one input byte: shift into the window, resolve matches, flush on the end mark
  task automatic find_replace_step(input in_item_t item);
    int unsigned plen;
    int unsigned rlen;
    out_item_t   step_out[$];
    out_item_t   r;
    plen = (pat_len_reg == 0) ? 1 :
           (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
    rlen = (rep_len_reg > MAX_REPLACE) ? MAX_REPLACE : rep_len_reg;
    if (win_fill < WIN_DEPTH) begin
      window[win_fill] = item.in_byte;
      win_fill++;
    end
    forever begin
      if (win_fill == plen && window_prefix_ok(plen)) begin
        for (int i = 0; i < rlen; i++)
          step_out.insert(step_out.size(), make_result(rep_word[i*BYTE_W +: BYTE_W], 1'b1));
        win_fill = 0;
        break;
      end
      if (win_fill < plen && window_prefix_ok(win_fill)) break;
      step_out.insert(step_out.size(), make_result(window_take_oldest(), 1'b1));
    end
    if (item.in_last) begin
      while (win_fill > 0 && step_out.size() < WIN_DEPTH)
        step_out.insert(step_out.size(), make_result(window_take_oldest(), 1'b1));
      win_fill = 0;
      if (step_out.size() == 0) begin
        r = make_result('0, 1'b0);
      end else begin
        r = step_out.pop_back();
      end
      r.out_last = 1'b1;
      step_out.insert(step_out.size(), r);
    end
    foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
  endtask

  // register writes, result compare, then prediction for the accepted request
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pat_word    = '0;
      pat_len_reg = 4'd1;
      rep_word    = '0;
      rep_len_reg = '0;
      foreach (window[i]) window[i] = '0;
      win_fill = 0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_AW-1:3]))
          REG_PATTERN_BYTES: pat_word = pwdata[WORD_W-1:0];
          REG_PATTERN_LEN: begin
            pat_len_reg = pwdata[CNT_W-1:0];
            win_fill    = 0;
          end
          REG_REPLACE_BYTES: rep_word = pwdata[WORD_W-1:0];
          REG_REPLACE_LEN: rep_len_reg = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 8'h00, out_data.out_byte);
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_data.out_byte);
          if (out_data.has_byte !== want.has_byte)
            report_mismatch("has_byte", 8'(want.has_byte), 8'(out_data.has_byte));
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", 8'(want.out_last), 8'(out_data.out_last));
        end
      end
      if (push && !full) find_replace_step(in_data);
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/testbench.sv @@
// top of the find-and-replace bench: clock, reset, stimulus, receiver and verdict
module testbench;
  import pfr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 320;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              push;
  logic              full;
  in_item_t          in_data;
  logic              empty;
  logic              pop;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int pending;
  int sent_items = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int idle_cycles = 0;
  bit hold_req;

  // pattern as the stimulus sees it, used to build strings that match
  logic [63:0] cur_pat = '0;
  int          cur_plen = 1;

  always #HALF_PERIOD clk = ~clk;

  pattern_find_replace u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pfr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data       (in_data),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  // mostly no gap, some short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte request and return at the edge that takes it
  task automatic send_item(input logic [7:0] b, input bit last, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{in_byte: b, in_last: last};
    do @(negedge clk); while (full);
    @(posedge clk);
    sent_items++;
  endtask

  // stop offering and wait until every owed result is out
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup and access phase; the bus stays selected for a following write
  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
  endtask

  task automatic cfg_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] rep, input logic [3:0] rlen);
    cfg_write(REG_PATTERN_BYTES, pat);
    cfg_write(REG_PATTERN_LEN, 64'(plen));
    cfg_write(REG_REPLACE_BYTES, rep);
    cfg_write(REG_REPLACE_LEN, 64'(rlen));
    cfg_idle();
    cur_pat  = pat;
    cur_plen = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
  endtask

  // string built mostly from whole and partial copies of the pattern
  task automatic send_string(input int len, input bit with_last, input bit steady);
    logic [7:0] text[$];
    int         r;
    int         n;
    while (text.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        for (int k = 0; k < cur_plen; k++) text.insert(text.size(), cur_pat[k*8 +: 8]);
      end else if (r < 60) begin
        n = $urandom_range(1, cur_plen);
        for (int k = 0; k < n; k++) text.insert(text.size(), cur_pat[k*8 +: 8]);
      end else if (r < 80) begin
        n = $urandom_range(0, cur_plen - 1);
        text.insert(text.size(), cur_pat[n*8 +: 8]);
      end else begin
        text.insert(text.size(), 8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < len; i++) send_item(text[i], with_last && (i == len - 1), steady);
  endtask

  task automatic random_config();
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int          r;
    r = $urandom_range(0, 9);
    if (r == 0) plen = 4'd0;
    else if (r == 1) plen = 4'($urandom_range(9, 15));
    else if (r == 2) plen = 4'd8;
    else if (r == 3) plen = 4'd1;
    else plen = 4'($urandom_range(1, 8));
    r = $urandom_range(0, 9);
    if (r == 0) rlen = 4'd0;
    else if (r == 1) rlen = 4'($urandom_range(9, 15));
    else if (r == 2) rlen = 4'd8;
    else rlen = 4'($urandom_range(0, 8));
    r = $urandom_range(0, 9);
    if (r < 3) begin
      // two-letter alphabet gives self-overlapping patterns
      for (int k = 0; k < 8; k++) pat[k*8 +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
    end else if (r == 3) begin
      pat = '0;
    end else if (r == 4) begin
      pat = '1;
    end else begin
      pat = {$urandom, $urandom};
    end
    r = $urandom_range(0, 9);
    if (r == 0) rep = '0;
    else if (r == 1) rep = '1;
    else rep = {$urandom, $urandom};
    set_config(pat, plen, rep, rlen);
  endtask

  // receiver: random pops, plus one long hold-off while the sender keeps pushing
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap(recv_calm);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int  phase;
    int  target;
    bit  pressure;
    rst_n    <= 1'b0;
    push     <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    hold_req <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration strips zero bytes
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);

    // "ab" to "XYZ": match, restart after a broken prefix, extremes, flush of a partial match
    settle();
    set_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);

    // zero pattern length acts as one; stripping leaves an end-only mark
    settle();
    set_config(64'hFF, 4'd0, 64'h0, 4'd0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);

    // oversized lengths saturate: eight-byte pattern gives eight replacement bytes
    settle();
    set_config(64'h0706050403020100, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    for (int i = 0; i < 8; i++) send_item(8'(i), i == 7, 1'b0);

    // pattern bytes rewritten mid-string keep the window; length rewrite drops it
    settle();
    set_config(64'h6261, 4'd2, 64'h51, 4'd1);
    send_item(8'h61, 1'b0, 1'b0);
    settle();
    cfg_write(REG_PATTERN_BYTES, 64'h6463);
    cfg_idle();
    cur_pat = 64'h6463;
    send_item(8'h64, 1'b0, 1'b0);
    send_item(8'h63, 1'b0, 1'b0);
    settle();
    cfg_write(REG_PATTERN_LEN, 64'd2);
    cfg_idle();
    send_item(8'h78, 1'b1, 1'b0);

    // random phases, each under a fresh configuration
    target = sent_items + RANDOM_ITEMS;
    phase  = 0;
    while (sent_items < target) begin
      settle();
      random_config();
      pressure = (phase == 2);
      if (pressure) begin
        hold_req <= 1'b1;
        repeat (4) send_string($urandom_range(10, 40), 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_string($urandom_range(1, 20), 1'b1, 1'b0);
      end
      // sometimes leave a string open across the next configuration
      if ($urandom_range(0, 4) == 0) send_string($urandom_range(1, 5), 1'b0, 1'b0);
      phase++;
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/pfr_pkg.sv
src/pfr_cfg.sv
src/pfr_front.sv
src/pfr_queue.sv
src/pfr_back.sv
src/pattern_find_replace.sv
bench/pfr_checker.sv
bench/testbench.sv
